// ===== hdl/tpq_pkg.sv =====
`default_nettype none

package tpq_pkg;

   localparam int unsigned QUEUE_DEPTH = 64;
   localparam int unsigned ID_COUNT    = 64;

   localparam int NUM_LVL = 3;
   localparam int ID_W    = 6;
   localparam int LVL_W   = 2;
   localparam int CMD_W   = 2;
   localparam int ST_W    = 2;
   localparam int RC_W    = 8;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 16;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = $clog2(2 * QUEUE_DEPTH);

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

   // status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

   // priority levels
   localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
   localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
   localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;
   localparam logic [LVL_W-1:0] LVL_NONE = 2'd3;

   typedef struct packed {
      logic            load;
      logic            pop_sel;
      logic            pop_rd;
      logic            pop_take;
      logic            push;
      logic            rm_init;
      logic            rm_rd;
      logic            rm_chk;
      logic            rm_end;
      logic            set_status;
      logic [ST_W-1:0] code;
      logic            rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             level_ok;
      logic             id_ok;
      logic             full;
      logic             any_ready;
      logic             rm_done;
      logic             rm_found;
      logic             rsp_free;
   } dp_stat_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] r;
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = idx + IDX_W'(1);
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] tail_idx(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] cnt);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(cnt);
      if (s >= SUM_W'(QUEUE_DEPTH)) s = s - SUM_W'(QUEUE_DEPTH);
      return IDX_W'(s);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/three_level_priority_ready_queue_unit.sv =====
`default_nettype none

// Channel  Dir  Ports              Payload (low bit up)
// req      in   req_tvalid/tready  tdata: cmd[1:0] thread_id[7:2] priority_req[9:8], 0 pad
// rsp      out  rsp_tvalid/tready  tdata: popped_id[5:0] status[7:6] ready_count[15:8]
//
// Push, no-op and any rejected command go from accept through decode to the response state;
// pop adds a memory read state and a take state. Remove walks the named queue through the
// queue memory with registered read, with a read state and a check state per entry.
// Reset clears counts, heads and the state machine; queue memory is not cleared.
// A new beat is accepted while the previous result waits in the output register; a
// finished command waits in the response state until that register frees up.
module three_level_priority_ready_queue_unit
   import tpq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // cmd, thread_id, priority_req
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata    // popped_id, status, ready_count
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   tpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tpq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

// ===== hdl/tpq_ctrl.sv =====
`default_nettype none

module tpq_ctrl
   import tpq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire dp_stat_type stat,
   output ctl_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_POP_RD = 3'd2;
   localparam logic [2:0] S_POP    = 3'd3;
   localparam logic [2:0] S_RM_RD  = 3'd4;
   localparam logic [2:0] S_RM_CHK = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            unique case (stat.op)
               CMD_PUSH: begin
                  cmd.set_status = 1'b1;
                  if (stat.level_ok && stat.id_ok && !stat.full) begin
                     cmd.push = 1'b1;
                     cmd.code = ST_OK;
                  end else begin
                     cmd.code = ST_FULL;
                  end
               end
               CMD_POP: begin
                  if (stat.any_ready) begin
                     cmd.pop_sel = 1'b1;
                     state_in    = S_POP_RD;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.code       = ST_EMPTY;
                  end
               end
               CMD_REMOVE: begin
                  if (stat.level_ok && stat.id_ok) begin
                     cmd.rm_init = 1'b1;
                     state_in    = S_RM_RD;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.code       = ST_NOT_FOUND;
                  end
               end
               CMD_NOP: begin
               end
               default: begin
               end
            endcase
         end
         S_POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_POP;
         end
         S_POP: begin
            cmd.pop_take = 1'b1;
            state_in     = S_RESP;
         end
         S_RM_RD: begin
            if (stat.rm_done) begin
               cmd.rm_end     = 1'b1;
               cmd.set_status = 1'b1;
               cmd.code       = stat.rm_found ? ST_OK : ST_NOT_FOUND;
               state_in       = S_RESP;
            end else begin
               cmd.rm_rd = 1'b1;
               state_in  = S_RM_CHK;
            end
         end
         S_RM_CHK: begin
            cmd.rm_chk = 1'b1;
            state_in   = S_RM_RD;
         end
         S_RESP: begin
            // hold until the output register is free
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== hdl/tpq_dpath.sv =====
`default_nettype none

module tpq_dpath
   import tpq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   input  wire ctl_cmd_type      cmd,
   output dp_stat_type           stat
);

   // three queues, each a circular buffer with its own head pointer
   logic [ID_W-1:0] queue_mem [NUM_LVL][QUEUE_DEPTH];

   logic [CNT_W-1:0] cnt_ff  [NUM_LVL];
   logic [CNT_W-1:0] cnt_in  [NUM_LVL];
   logic [IDX_W-1:0] head_ff [NUM_LVL];
   logic [IDX_W-1:0] head_in [NUM_LVL];

   logic [CMD_W-1:0] op_ff,  op_in;
   logic [ID_W-1:0]  id_ff,  id_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0] wr_cnt_ff, wr_cnt_in;

   logic [ID_W-1:0]  rdata_ff;
   logic [ID_W-1:0]  res_id_ff, res_id_in;
   logic [ST_W-1:0]  res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0] sel_cnt;
   logic [IDX_W-1:0] sel_head;
   logic [LVL_W-1:0] pop_lvl;
   logic [LVL_W-1:0] rd_lvl;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [ID_W-1:0]  wr_data;
   logic             mem_we;
   logic             keep;
   logic [CNT_W+1:0] total;

   always_comb begin
      sel_cnt  = '0;
      sel_head = '0;
      for (int l = 0; l < NUM_LVL; l++) begin
         if (lvl_ff == LVL_W'(l)) begin
            sel_cnt  = cnt_ff[l];
            sel_head = head_ff[l];
         end
      end
   end

   always_comb begin
      priority if (cnt_ff[0] != '0) pop_lvl = LVL_HIGH;
      else if (cnt_ff[1] != '0) pop_lvl = LVL_MID;
      else pop_lvl = LVL_LOW;
   end

   assign total = (CNT_W+2)'(cnt_ff[0]) + (CNT_W+2)'(cnt_ff[1]) + (CNT_W+2)'(cnt_ff[2]);

   assign stat.op        = op_ff;
   assign stat.level_ok  = (lvl_ff != LVL_NONE);
   assign stat.id_ok     = (32'(id_ff) < ID_COUNT);
   assign stat.full      = (sel_cnt == CNT_W'(QUEUE_DEPTH));
   assign stat.any_ready = (cnt_ff[0] != '0) || (cnt_ff[1] != '0) || (cnt_ff[2] != '0);
   assign stat.rm_done   = (rd_cnt_ff == sel_cnt);
   assign stat.rm_found  = (wr_cnt_ff != sel_cnt);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   // memory ports
   assign rd_lvl  = (lvl_ff == LVL_NONE) ? LVL_HIGH : lvl_ff;
   assign rd_addr = cmd.pop_rd ? sel_head : rd_ptr_ff;
   assign keep    = (rdata_ff != id_ff);
   assign mem_we  = cmd.push || (cmd.rm_chk && keep);
   assign wr_addr = cmd.push ? tail_idx(sel_head, sel_cnt) : wr_ptr_ff;
   assign wr_data = cmd.push ? id_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) queue_mem[lvl_ff][wr_addr] <= wr_data;
      rdata_ff <= queue_mem[rd_lvl][rd_addr];
   end

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      for (int l = 0; l < NUM_LVL; l++) begin
         if (lvl_ff == LVL_W'(l)) begin
            if (cmd.push) cnt_in[l] = cnt_ff[l] + CNT_W'(1);
            if (cmd.pop_take) begin
               cnt_in[l]  = cnt_ff[l] - CNT_W'(1);
               head_in[l] = idx_inc(head_ff[l]);
            end
            if (cmd.rm_end) cnt_in[l] = wr_cnt_ff;
         end
      end

      op_in  = cmd.load ? req_tdata[1:0] : op_ff;
      id_in  = cmd.load ? req_tdata[7:2] : id_ff;
      lvl_in = lvl_ff;
      if (cmd.load) lvl_in = req_tdata[9:8];
      else if (cmd.pop_sel) lvl_in = pop_lvl;

      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_cnt_in = rd_cnt_ff;
      wr_cnt_in = wr_cnt_ff;
      if (cmd.rm_init) begin
         rd_ptr_in = sel_head;
         wr_ptr_in = sel_head;
         rd_cnt_in = '0;
         wr_cnt_in = '0;
      end
      if (cmd.rm_rd) begin
         rd_ptr_in = idx_inc(rd_ptr_ff);
         rd_cnt_in = rd_cnt_ff + CNT_W'(1);
      end
      // compact: kept entries slide down to the write pointer
      if (cmd.rm_chk && keep) begin
         wr_ptr_in = idx_inc(wr_ptr_ff);
         wr_cnt_in = wr_cnt_ff + CNT_W'(1);
      end

      res_id_in = res_id_ff;
      if (cmd.load) res_id_in = '0;
      else if (cmd.pop_take) res_id_in = rdata_ff;

      res_status_in = res_status_ff;
      if (cmd.load) res_status_in = ST_OK;
      else if (cmd.set_status) res_status_in = cmd.code;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {RC_W'(total), res_status_ff, res_id_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LVL; l++) begin
            cnt_ff[l]  <= '0;
            head_ff[l] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      lvl_ff        <= lvl_in;
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      rd_cnt_ff     <= rd_cnt_in;
      wr_cnt_ff     <= wr_cnt_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[0] <= CNT_W'(QUEUE_DEPTH)) && (cnt_ff[1] <= CNT_W'(QUEUE_DEPTH)) &&
      (cnt_ff[2] <= CNT_W'(QUEUE_DEPTH)))
      else $error("queue count above depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (lvl_ff != LVL_NONE) && (sel_cnt < CNT_W'(QUEUE_DEPTH)))
      else $error("push into full or missing queue");

   a_compact: assert property (@(posedge clock) disable iff (reset)
      (cmd.rm_rd || cmd.rm_chk || cmd.rm_end) |-> (wr_cnt_ff <= rd_cnt_ff))
      else $error("compaction write ahead of read");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before taken");

endmodule

`default_nettype wire
